### sv/i2csbe_pkg.sv
// Package with the types and constants shared by the I2C slave byte engine.
`default_nettype none

package i2csbe_pkg;

  localparam int unsigned DefaultBufDepth = 32;

  // Acknowledge levels shifted out on SDA.
  localparam logic [7:0] AckLevel  = 8'h00;
  localparam logic [7:0] NackLevel = 8'h80;

  // Largest number of bytes the engine accepts in one master write.
  localparam logic [5:0] MaxCapacity = 6'd32;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_SHIFT   = 2'd1,
    CMD_SERVICE = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_OWN_ADDRESS    = 2'd0,
    REG_READ_LENGTH    = 2'd1,
    REG_WRITE_CAPACITY = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_WAIT     = 2'd0,
    MODE_TRANSFER = 2'd1,
    MODE_HOLD     = 2'd2
  } bus_mode_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ADDR     = 3'd1,
    PH_TX_LOAD  = 3'd2,
    PH_TX_SENT  = 3'd3,
    PH_TX_ACK   = 3'd4,
    PH_RX_ACKED = 3'd5,
    PH_RX_DATA  = 3'd6,
    PH_SERVICE  = 3'd7
  } phase_e;

  // One result item; tx_byte is replaced by buffer read data when from_buf is set.
  typedef struct packed {
    logic       from_buf;
    logic [7:0] tx_byte;
    logic       sda_drive;
    logic [1:0] bus_mode;
    logic [3:0] shift_length;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_index;
    logic       write_done;
    logic [5:0] done_count;
    logic       event_ignored;
  } result_t;

endpackage

`default_nettype wire

### sv/i2c_slave_byte_engine.sv
// Top level of the I2C slave byte engine: event decoder, control state and read buffer.
//
//  Channel  | Direction | Handshake                 | Payload
//  s_axis   | in        | s_axis_tvalid/tready      | tuser cmd, tlast stop_flag, tdata rest
//  m_axis   | out       | m_axis_tvalid/tready      | tdata result fields
//  cfg      | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One event is accepted per cycle while the output register can take it, and its result is
// registered in the output register, where the read buffer's registered read port
// supplies the transmit byte. Input is accepted whenever the output register is empty
// or being drained in the same cycle. Reset clears the control state, the configuration
// registers and the output valid flag; read buffer contents stay undefined until loaded.
`default_nettype none

module i2c_slave_byte_engine #(
  parameter int unsigned BUF_DEPTH = i2csbe_pkg::DefaultBufDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] shift_data, [12:8] load_index, [20:13] load_data, [23:21] zero
  input  wire logic [23:0] s_axis_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_axis_tuser,
  // stop_flag
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] tx_byte, [8] sda_drive, [10:9] bus_mode, [14:11] shift_length,
  // [15] rx_valid, [23:16] rx_byte, [28:24] rx_index, [29] write_done,
  // [35:30] done_count, [36] event_ignored, [39:37] zero
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i
);
  import i2csbe_pkg::*;

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned XW = (AW > 6) ? AW : 6;

  // Input fields.
  cmd_e       cmd;
  logic [7:0] shift_data;
  logic       stop_flag;
  logic [4:0] load_index;
  logic [7:0] load_data;

  assign cmd        = cmd_e'(s_axis_tuser);
  assign shift_data = s_axis_tdata[7:0];
  assign load_index = s_axis_tdata[12:8];
  assign load_data  = s_axis_tdata[20:13];
  assign stop_flag  = s_axis_tlast;

  // Configuration registers.
  logic [6:0] own_address_q;
  logic [5:0] read_length_q, write_capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q    <= '0;
      read_length_q    <= '0;
      write_capacity_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OWN_ADDRESS:    own_address_q    <= cfg_data_i;
        REG_READ_LENGTH:    read_length_q    <= cfg_data_i[5:0];
        REG_WRITE_CAPACITY: write_capacity_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Control state.
  phase_e     phase_q, phase_d;
  logic [5:0] read_pointer_q, read_pointer_d;
  logic [5:0] write_count_q, write_count_d;

  logic    accept;
  logic    m_valid_q;
  result_t res_q, res_d;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Shared decode.
  logic [5:0] len_sat, cap_sat;
  logic       tx_more, rx_room, addr_match;

  assign len_sat    = (32'(read_length_q) > BUF_DEPTH) ? 6'(BUF_DEPTH) : read_length_q;
  assign cap_sat    = (write_capacity_q > MaxCapacity) ? MaxCapacity : write_capacity_q;
  assign tx_more    = read_pointer_q < len_sat;
  assign rx_room    = write_count_q < cap_sat;
  assign addr_match = shift_data[7:1] == own_address_q;

  // Next state.
  always_comb begin
    phase_d        = phase_q;
    read_pointer_d = read_pointer_q;
    write_count_d  = write_count_q;
    unique case (cmd)
      CMD_START: begin
        if (phase_q == PH_IDLE) phase_d = PH_ADDR;
      end
      CMD_SHIFT: begin
        unique case (phase_q)
          PH_ADDR: begin
            if (!addr_match) begin
              phase_d = PH_IDLE;
            end else if (shift_data[0]) begin
              phase_d        = PH_TX_LOAD;
              read_pointer_d = '0;
            end else begin
              phase_d       = PH_RX_ACKED;
              write_count_d = '0;
            end
          end
          PH_TX_ACK, PH_TX_LOAD: begin
            if ((phase_q == PH_TX_ACK && shift_data != 8'd0) || !tx_more) begin
              phase_d = PH_IDLE;
            end else begin
              phase_d        = PH_TX_SENT;
              read_pointer_d = read_pointer_q + 6'd1;
            end
          end
          PH_TX_SENT:  phase_d = PH_TX_ACK;
          PH_RX_ACKED: phase_d = stop_flag ? PH_SERVICE : PH_RX_DATA;
          PH_RX_DATA: begin
            phase_d = PH_RX_ACKED;
            if (rx_room) write_count_d = write_count_q + 6'd1;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      CMD_SERVICE: begin
        if (phase_q == PH_SERVICE) phase_d = PH_IDLE;
      end
      CMD_LOAD: ;
      default: ;
    endcase
  end

  // Result fields.
  always_comb begin
    res_d = '0;
    unique case (cmd)
      CMD_START: begin
        if (phase_q != PH_IDLE) res_d.event_ignored = 1'b1;
        else res_d.shift_length = 4'd8;
      end
      CMD_SHIFT: begin
        unique case (phase_q)
          PH_ADDR: begin
            if (addr_match) begin
              res_d.tx_byte      = AckLevel;
              res_d.sda_drive    = 1'b1;
              res_d.shift_length = 4'd1;
            end
          end
          PH_TX_ACK, PH_TX_LOAD: begin
            if (!((phase_q == PH_TX_ACK && shift_data != 8'd0) || !tx_more)) begin
              res_d.from_buf     = 1'b1;
              res_d.sda_drive    = 1'b1;
              res_d.shift_length = 4'd8;
            end
          end
          PH_TX_SENT: res_d.shift_length = 4'd1;
          PH_RX_ACKED: begin
            if (stop_flag) begin
              res_d.write_done = 1'b1;
              res_d.done_count = write_count_q;
            end else begin
              res_d.shift_length = 4'd8;
            end
          end
          PH_RX_DATA: begin
            res_d.sda_drive    = 1'b1;
            res_d.shift_length = 4'd1;
            if (rx_room) begin
              res_d.rx_valid = 1'b1;
              res_d.rx_byte  = shift_data;
              res_d.rx_index = write_count_q[4:0];
              res_d.tx_byte  = AckLevel;
            end else begin
              res_d.tx_byte = NackLevel;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (phase_d == PH_IDLE) res_d.bus_mode = MODE_WAIT;
    else if (phase_d == PH_SERVICE) res_d.bus_mode = MODE_HOLD;
    else res_d.bus_mode = MODE_TRANSFER;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      read_pointer_q <= '0;
      write_count_q  <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      if (accept) begin
        phase_q        <= phase_d;
        read_pointer_q <= read_pointer_d;
        write_count_q  <= write_count_d;
      end
      if (s_axis_tready) m_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  // Read buffer: one write port for loads, one registered read port for transmit.
  logic [7:0]    mem_q [BUF_DEPTH];
  logic [7:0]    rd_data_q;
  logic [XW-1:0] rd_ext, wr_ext;
  logic          mem_we, mem_re;

  assign rd_ext = XW'(read_pointer_q);
  assign wr_ext = XW'(load_index);
  assign mem_we = accept && cmd == CMD_LOAD && 32'(load_index) < BUF_DEPTH;
  assign mem_re = accept && res_d.from_buf;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_ext[AW-1:0]] <= load_data;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_data_q <= mem_q[rd_ext[AW-1:0]];
  end

  // Output channel.
  logic [7:0] tx_out;

  assign tx_out        = res_q.from_buf ? rd_data_q : res_q.tx_byte;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.event_ignored, res_q.done_count, res_q.write_done,
                          res_q.rx_index, res_q.rx_byte, res_q.rx_valid,
                          res_q.shift_length, res_q.bus_mode, res_q.sda_drive, tx_out};

  // Checks.
  a_wc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_count_q <= MaxCapacity)
    else $error("write count beyond capacity limit");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_axis_tready && res_q.from_buf |=> $stable(rd_data_q))
    else $error("buffer read data changed under a stalled result");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CMD_START && phase_q != PH_IDLE |=> phase_q == $past(phase_q))
    else $error("ignored start changed the phase");

  a_rx_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(res_q.rx_valid && res_q.write_done))
    else $error("received byte and write completion in one result");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the I2C slave byte engine with directed and random bus traffic.
module tb;
  import i2csbe_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomEvents = 1650;
  localparam logic [5:0]  BufDepth     = 6'(DefaultBufDepth);

  typedef enum logic [1:0] {
    OP_EVENT  = 2'd0,
    OP_CONFIG = 2'd1,
    OP_DRAIN  = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    cmd_e       cmd;
    logic [7:0] shift_data;
    logic       stop;
    logic [4:0] load_index;
    logic [7:0] load_data;
    reg_idx_e   reg_idx;
    logic [6:0] reg_value;
    logic [4:0] gap;
  } bus_op_t;

  // Same layout as m_axis_tdata, highest field first.
  typedef struct packed {
    logic [2:0] reserved;
    logic       event_ignored;
    logic [5:0] done_count;
    logic       write_done;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [3:0] shift_length;
    logic [1:0] bus_mode;
    logic       sda_drive;
    logic [7:0] tx_byte;
  } reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [6:0]  cfg_data_i    = '0;

  i2c_slave_byte_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  bus_op_t     bus_events_todo[$];
  reply_t      bus_replies_due[$];
  int unsigned events_queued   = 0;
  int unsigned replies_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  logic        in_taken        = 1'b0;
  logic        out_taken       = 1'b0;

  // Engine state and registers as the checker sees them.
  phase_e     eng_phase;
  logic [5:0] eng_rd_ptr;
  logic [5:0] eng_wr_count;
  logic [7:0] eng_rd_buf [DefaultBufDepth];
  logic [6:0] eng_own_addr;
  logic [5:0] eng_rd_len;
  logic [5:0] eng_wr_cap;

  // Settings as the stimulus generator sees them.
  logic [6:0]  gen_own     = '0;
  logic [5:0]  gen_len     = '0;
  logic [5:0]  gen_cap     = '0;
  logic [31:0] loaded_mask = '0;
  logic        tx_steady   = 1'b0;

  function automatic reply_t engine_step(cmd_e cmd, logic [7:0] data, logic stop,
                                         logic [4:0] lidx, logic [7:0] ldat);
    reply_t     r;
    logic [5:0] limit;
    r = '0;
    case (cmd)
      CMD_START: begin
        if (eng_phase != PH_IDLE) begin
          r.event_ignored = 1'b1;
        end else begin
          r.shift_length = 4'd8;
          eng_phase = PH_ADDR;
        end
      end
      CMD_SHIFT: begin
        case (eng_phase)
          PH_ADDR: begin
            if (data[7:1] != eng_own_addr) begin
              eng_phase = PH_IDLE;
            end else begin
              if (data[0]) begin
                eng_phase = PH_TX_LOAD;
                eng_rd_ptr = '0;
              end else begin
                eng_phase = PH_RX_ACKED;
                eng_wr_count = '0;
              end
              r.tx_byte = AckLevel;
              r.sda_drive = 1'b1;
              r.shift_length = 4'd1;
            end
          end
          PH_TX_LOAD, PH_TX_ACK: begin
            limit = (eng_rd_len > BufDepth) ? BufDepth : eng_rd_len;
            // A master NACK or a spent buffer ends the read.
            if ((eng_phase == PH_TX_ACK && data != 8'h00) || eng_rd_ptr >= limit) begin
              eng_phase = PH_IDLE;
            end else begin
              r.tx_byte = eng_rd_buf[eng_rd_ptr[4:0]];
              eng_rd_ptr = eng_rd_ptr + 6'd1;
              r.sda_drive = 1'b1;
              r.shift_length = 4'd8;
              eng_phase = PH_TX_SENT;
            end
          end
          PH_TX_SENT: begin
            r.shift_length = 4'd1;
            eng_phase = PH_TX_ACK;
          end
          PH_RX_ACKED: begin
            if (stop) begin
              r.write_done = 1'b1;
              r.done_count = eng_wr_count;
              eng_phase = PH_SERVICE;
            end else begin
              r.shift_length = 4'd8;
              eng_phase = PH_RX_DATA;
            end
          end
          PH_RX_DATA: begin
            limit = (eng_wr_cap > MaxCapacity) ? MaxCapacity : eng_wr_cap;
            if (eng_wr_count < limit) begin
              r.rx_valid = 1'b1;
              r.rx_byte = data;
              r.rx_index = eng_wr_count[4:0];
              eng_wr_count = eng_wr_count + 6'd1;
              r.tx_byte = AckLevel;
            end else begin
              r.tx_byte = NackLevel;
            end
            r.sda_drive = 1'b1;
            r.shift_length = 4'd1;
            eng_phase = PH_RX_ACKED;
          end
          default: eng_phase = PH_IDLE;
        endcase
      end
      CMD_SERVICE: begin
        if (eng_phase == PH_SERVICE) eng_phase = PH_IDLE;
      end
      default: eng_rd_buf[lidx] = ldat;
    endcase
    if (eng_phase == PH_IDLE) r.bus_mode = MODE_WAIT;
    else if (eng_phase == PH_SERVICE) r.bus_mode = MODE_HOLD;
    else r.bus_mode = MODE_TRANSFER;
    return r;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [6:0] pick_setting(logic [6:0] top);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return top;
      2: return 7'd32;
      default: return 7'($urandom_range(0, top));
    endcase
  endfunction

  task automatic push_event(cmd_e cmd, logic [7:0] data, logic stop, logic [4:0] lidx,
                            logic [7:0] ldat);
    bus_op_t op;
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
    op = '0;
    op.kind = OP_EVENT;
    op.cmd = cmd;
    op.shift_data = data;
    op.stop = stop;
    op.load_index = lidx;
    op.load_data = ldat;
    op.gap = tx_steady ? 5'd0 : 5'($urandom_range(0, 16));
    bus_events_todo.push_back(op);
    events_queued++;
    if (cmd == CMD_LOAD) loaded_mask[lidx] = 1'b1;
  endtask

  task automatic shift_in(logic [7:0] data, logic stop);
    push_event(CMD_SHIFT, data, stop, 5'($urandom), 8'($urandom));
  endtask

  task automatic bus_cmd(cmd_e cmd);
    push_event(cmd, 8'($urandom), 1'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic load_byte(logic [4:0] lidx, logic [7:0] ldat);
    push_event(CMD_LOAD, 8'($urandom), 1'($urandom), lidx, ldat);
  endtask

  task automatic drain_pause();
    bus_op_t op;
    op = '0;
    op.kind = OP_DRAIN;
    bus_events_todo.push_back(op);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [6:0] value);
    bus_op_t op;
    // Never let a read reach a buffer entry that was not loaded.
    if (idx == REG_READ_LENGTH) begin
      for (int i = 0; i < DefaultBufDepth; i++)
        if (i < value[5:0] && !loaded_mask[i]) load_byte(5'(i), 8'($urandom));
    end
    op = '0;
    op.kind = OP_CONFIG;
    op.reg_idx = idx;
    op.reg_value = value;
    bus_events_todo.push_back(op);
    case (idx)
      REG_OWN_ADDRESS:    gen_own = value;
      REG_READ_LENGTH:    gen_len = value[5:0];
      REG_WRITE_CAPACITY: gen_cap = value[5:0];
      default: ;
    endcase
  endtask

  // Driver: offers one event at a time after its gap, and writes registers only when empty.
  logic [4:0] tx_gap_left = '0;
  logic       gap_loaded  = 1'b0;

  always @(negedge clk_i) begin
    bus_op_t op;
    logic    offer;
    logic    write_en;
    offer = s_axis_tvalid && !in_taken;
    write_en = 1'b0;
    if (rst_ni && !offer && bus_events_todo.size() != 0) begin
      op = bus_events_todo[0];
      case (op.kind)
        OP_EVENT: begin
          if (!gap_loaded) begin
            tx_gap_left = op.gap;
            gap_loaded = 1'b1;
          end
          if (tx_gap_left != 0) begin
            tx_gap_left = tx_gap_left - 5'd1;
          end else begin
            s_axis_tuser <= op.cmd;
            s_axis_tlast <= op.stop;
            s_axis_tdata <= {3'b000, op.load_data, op.load_index, op.shift_data};
            offer = 1'b1;
            gap_loaded = 1'b0;
            void'(bus_events_todo.pop_front());
          end
        end
        OP_CONFIG: begin
          if (bus_replies_due.size() == 0) begin
            cfg_idx_i <= op.reg_idx;
            cfg_data_i <= op.reg_value;
            write_en = 1'b1;
            void'(bus_events_todo.pop_front());
          end
        end
        default: begin
          if (bus_replies_due.size() == 0) void'(bus_events_todo.pop_front());
        end
      endcase
    end
    s_axis_tvalid <= offer;
    cfg_we_i <= write_en;
  end

  // Receiver: a random stall before each result, plus two long hold-offs.
  int unsigned rx_stall_left = 0;
  int unsigned rx_hold_left  = 0;
  int unsigned next_hold_at  = 300;
  logic        rx_steady     = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (replies_checked >= next_hold_at) begin
        rx_hold_left = 300;
        next_hold_at = next_hold_at + 800;
      end
      if (out_taken) begin
        if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
        rx_stall_left = rx_steady ? 0 : $urandom_range(0, 16);
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted event and checks each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      eng_phase = PH_IDLE;
      eng_rd_ptr = '0;
      eng_wr_count = '0;
      eng_own_addr = '0;
      eng_rd_len = '0;
      eng_wr_cap = '0;
      for (int i = 0; i < DefaultBufDepth; i++) eng_rd_buf[i] = '0;
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        if (cfg_we_i) begin
          case (cfg_idx_i)
            REG_OWN_ADDRESS:    eng_own_addr = cfg_data_i;
            REG_READ_LENGTH:    eng_rd_len = cfg_data_i[5:0];
            REG_WRITE_CAPACITY: eng_wr_cap = cfg_data_i[5:0];
            default: ;
          endcase
        end
        out_taken <= m_axis_tvalid && m_axis_tready;
        if (m_axis_tvalid && m_axis_tready) begin
          got = reply_t'(m_axis_tdata);
          if (bus_replies_due.size() == 0) begin
            $error("result 0x%h arrived with nothing expected", m_axis_tdata);
            mismatches++;
          end else begin
            want = bus_replies_due.pop_front();
            check_field("tx_byte", want.tx_byte, got.tx_byte);
            check_field("sda_drive", want.sda_drive, got.sda_drive);
            check_field("bus_mode", want.bus_mode, got.bus_mode);
            check_field("shift_length", want.shift_length, got.shift_length);
            check_field("rx_valid", want.rx_valid, got.rx_valid);
            check_field("rx_byte", want.rx_byte, got.rx_byte);
            check_field("rx_index", want.rx_index, got.rx_index);
            check_field("write_done", want.write_done, got.write_done);
            check_field("done_count", want.done_count, got.done_count);
            check_field("event_ignored", want.event_ignored, got.event_ignored);
            check_field("reserved", want.reserved, got.reserved);
          end
          replies_checked++;
        end
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
          bus_replies_due.push_back(engine_step(cmd_e'(s_axis_tuser), s_axis_tdata[7:0],
                                                s_axis_tlast, s_axis_tdata[12:8],
                                                s_axis_tdata[20:13]));
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned span;
    int unsigned next_reconfig;

    // Directed opening: loads at both ends of the buffer, then one of each transfer.
    load_byte(5'd0, 8'hFF);
    load_byte(5'd1, 8'h00);
    load_byte(5'd2, 8'hA5);
    load_byte(5'd31, 8'h5A);
    write_reg(REG_OWN_ADDRESS, 7'h55);
    write_reg(REG_READ_LENGTH, 7'd3);
    write_reg(REG_WRITE_CAPACITY, 7'd2);
    write_reg(REG_UNUSED, 7'h7F);
    bus_cmd(CMD_SERVICE);
    shift_in(8'h00, 1'b0);
    bus_cmd(CMD_START);
    shift_in({7'h2A, 1'b0}, 1'b0);
    bus_cmd(CMD_START);
    bus_cmd(CMD_START);
    shift_in({7'h55, 1'b0}, 1'b0);
    shift_in(8'h00, 1'b0);
    shift_in(8'hFF, 1'b0);
    shift_in(8'h00, 1'b0);
    shift_in(8'h00, 1'b1);
    shift_in(8'h00, 1'b0);
    shift_in(8'h3C, 1'b0);
    shift_in(8'h00, 1'b1);
    bus_cmd(CMD_START);
    bus_cmd(CMD_SERVICE);
    bus_cmd(CMD_START);
    shift_in({7'h55, 1'b1}, 1'b0);
    shift_in(8'h00, 1'b0);
    shift_in(8'h00, 1'b0);
    shift_in(8'h00, 1'b0);
    shift_in(8'h00, 1'b0);
    shift_in(8'hFF, 1'b0);

    next_reconfig = events_queued;
    while (events_queued < RandomEvents) begin
      if (events_queued >= next_reconfig) begin
        next_reconfig = events_queued + 220;
        write_reg(REG_OWN_ADDRESS, pick_setting(7'd127));
        write_reg(REG_READ_LENGTH, pick_setting(7'd63) | {1'($urandom), 6'd0});
        write_reg(REG_WRITE_CAPACITY, pick_setting(7'd63) | {1'($urandom), 6'd0});
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Master write, now and then to a foreign address.
        bus_cmd(CMD_START);
        if ($urandom_range(0, 9) == 0) begin
          shift_in({gen_own ^ 7'($urandom_range(1, 127)), 1'($urandom)}, 1'($urandom));
        end else begin
          shift_in({gen_own, 1'b0}, 1'($urandom));
          span = (gen_cap > MaxCapacity) ? 32 : gen_cap;
          n = $urandom_range(0, span + 2);
          for (int i = 0; i < n; i++) begin
            shift_in(8'($urandom), 1'b0);
            shift_in(8'($urandom), 1'($urandom));
          end
          shift_in(8'($urandom), 1'b1);
          if ($urandom_range(0, 7) == 0) bus_cmd(CMD_START);
          bus_cmd(CMD_SERVICE);
        end
      end else if (pick < 75) begin
        // Master read: NACK after a random byte, or ACK until the buffer is spent.
        bus_cmd(CMD_START);
        shift_in({gen_own, 1'b1}, 1'($urandom));
        shift_in(8'($urandom), 1'($urandom));
        span = (gen_len > BufDepth) ? 32 : gen_len;
        n = $urandom_range(1, span + 1);
        for (int i = 0; i < span && i < n; i++) begin
          shift_in(8'($urandom), 1'($urandom));
          shift_in((i == n - 1) ? 8'($urandom_range(1, 255)) : 8'h00, 1'($urandom));
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) load_byte(5'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 4))
          push_event(cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 5'($urandom),
                     8'($urandom));
        // Four shifts of a foreign address with stop bring any phase back to idle.
        repeat (4) shift_in({~gen_own, 1'b1}, 1'b1);
      end else begin
        drain_pause();
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (replies_checked < events_queued) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && bus_replies_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
